FILE: hdl/mhs_pkg.sv
// ----------------------------------------------------------------------------
// mhs_pkg: shared types and constants of the marker header scanner
// Tag bytes, counter widths, result codes and the burst that the scan core
// hands to the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package mhs_pkg;

	localparam int MAX_MARKERS = 64;
	localparam int CNT_W       = $clog2(MAX_MARKERS + 1);
	localparam int TOT_W       = 7;
	localparam int POS_W       = 32;
	localparam int WORD_W      = 32;

	// The window holds the newest byte plus WIN_OLD earlier bytes: enough to
	// see the three header words when a header completes.
	localparam int HDR_BYTES = 12;
	localparam int WIN_OLD   = HDR_BYTES - 1;

	// Offset of the tag's first byte from its last byte, and from the byte
	// that completes its header.
	localparam int TAG_LAST = 3;
	localparam int CMP_AGE  = 15;

	// Tag tracking line: bit k set means a tag ended k+1 bytes ago.
	localparam int TRK_W = HDR_BYTES;

	// Result selection mask: top bit is the completed header, then the
	// truncated markers oldest first, bit 0 is the summary.
	localparam int SEL_W  = TRK_W + 2;
	localparam int PICK_W = $clog2(SEL_W);

	localparam int DATA_BITS = POS_W + 2 + 3 * WORD_W + 3 * TOT_W + 2 + 1;
	localparam int DATA_W    = ((DATA_BITS + 7) / 8) * 8;

	localparam logic [7:0] TAG_P = 8'h50;
	localparam logic [7:0] TAG_R = 8'h52;
	localparam logic [7:0] TAG_S = 8'h53;
	localparam logic [7:0] TAG_3 = 8'h33;

	typedef enum logic [1:0] {
		CLS_V1    = 2'd0,
		CLS_EXEC  = 2'd1,
		CLS_TRUNC = 2'd2
	} mclass_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SOURCE   = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	localparam logic KIND_MARKER  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [POS_W-1:0]       pos;
		logic [8*HDR_BYTES-1:0] hdr;
		mclass_t                cmp_class;
		logic [SEL_W-1:0]       sel;
		logic [TOT_W-1:0]       marker_total;
		logic [TOT_W-1:0]       record_total;
		logic [TOT_W-1:0]       trunc_total;
		status_t                status;
		logic                   complete;
	} burst_t;

endpackage

`default_nettype wire

FILE: hdl/mhs_scan_core.sv
// ----------------------------------------------------------------------------
// mhs_scan_core: byte window, tag detection and stream counters
// Updates the stream state on every accepted beat and builds the burst of
// results that the beat causes.
// ----------------------------------------------------------------------------
`default_nettype none

module mhs_scan_core
	import mhs_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic         cfg_wdata,
	input  wire logic         fire,
	input  wire logic [7:0]   data_byte,
	input  wire logic         final_byte,
	output burst_t            burst
);

	logic                   verified_q;
	logic [8*WIN_OLD-1:0]   win_q;
	logic [POS_W-1:0]       pos_q;
	logic [TRK_W-1:0]       trk_q;
	logic [CNT_W-1:0]       marker_cnt_q;
	logic [CNT_W-1:0]       record_cnt_q;
	logic                   overflow_q;
	logic                   long_q;

	logic [8*HDR_BYTES-1:0] hdr;
	logic                   tag_hit;
	logic                   tag_taken;
	logic                   overflow_d;
	logic                   cmp;
	logic                   cmp_v1;
	logic                   long_d;
	logic [TRK_W-1:0]       trunc_vec;
	logic [CNT_W-1:0]       marker_cnt_d;
	logic [CNT_W-1:0]       record_cnt_d;
	status_t                status;

	assign hdr = {win_q, data_byte};

	assign tag_hit = verified_q && win_q[23:16] == TAG_P && win_q[15:8] == TAG_R
		&& win_q[7:0] == TAG_S && data_byte == TAG_3;
	assign tag_taken  = tag_hit && !overflow_q && marker_cnt_q < CNT_W'(MAX_MARKERS);
	assign overflow_d = overflow_q || (tag_hit && !tag_taken);

	assign cmp    = trk_q[TRK_W-1];
	assign cmp_v1 = hdr[95:64] == WORD_W'(1) && hdr[63:32] != '0;

	assign long_d       = long_q || pos_q >= POS_W'(TAG_LAST);
	assign marker_cnt_d = marker_cnt_q + CNT_W'(tag_taken);
	assign record_cnt_d = record_cnt_q + CNT_W'(cmp && cmp_v1);

	// Markers still open at the end of the stream, bit i ended i bytes ago.
	assign trunc_vec = {trk_q[TRK_W-2:0], tag_taken};

	always_comb begin
		if (!verified_q || !long_d) begin
			status = ST_SOURCE;
		end else if (overflow_d) begin
			status = ST_OVERFLOW;
		end else begin
			status = ST_OK;
		end
		burst.pos          = pos_q;
		burst.hdr          = hdr;
		burst.cmp_class    = cmp_v1 ? CLS_V1 : CLS_EXEC;
		burst.sel          = {cmp, final_byte ? trunc_vec : TRK_W'(0), final_byte};
		burst.marker_total = TOT_W'(marker_cnt_d);
		burst.record_total = TOT_W'(record_cnt_d);
		burst.trunc_total  = TOT_W'($countones(trunc_vec));
		burst.status       = status;
		burst.complete     = status == ST_OK && marker_cnt_d != '0 && trunc_vec == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verified_q <= 1'b0;
		end else if (cfg_we) begin
			verified_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q        <= '0;
			pos_q        <= '0;
			trk_q        <= '0;
			marker_cnt_q <= '0;
			record_cnt_q <= '0;
			overflow_q   <= 1'b0;
			long_q       <= 1'b0;
		end else if (fire) begin
			if (final_byte) begin
				win_q        <= '0;
				pos_q        <= '0;
				trk_q        <= '0;
				marker_cnt_q <= '0;
				record_cnt_q <= '0;
				overflow_q   <= 1'b0;
				long_q       <= 1'b0;
			end else begin
				win_q        <= hdr[8*WIN_OLD-1:0];
				pos_q        <= pos_q + POS_W'(1);
				trk_q        <= trunc_vec;
				marker_cnt_q <= marker_cnt_d;
				record_cnt_q <= record_cnt_d;
				overflow_q   <= overflow_d;
				long_q       <= long_d;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/mhs_out_seq.sv
// ----------------------------------------------------------------------------
// mhs_out_seq: result burst holder and output register
// Holds the results of one input beat and moves them out one beat a cycle if
// ready: completed header first, truncated markers oldest first, summary last.
// ----------------------------------------------------------------------------
`default_nettype none

module mhs_out_seq
	import mhs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire burst_t            burst,
	output logic                   load_ready,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [DATA_W-1:0]      m_axis_tdata,
	output logic                   m_axis_tuser,
	output logic                   m_axis_tlast
);

	burst_t              held_q;
	logic [SEL_W-1:0]    mask_q;
	logic                out_valid_q;
	logic [DATA_W-1:0]   out_data_q;
	logic                out_kind_q;
	logic                out_last_q;

	logic                advance;
	logic [PICK_W-1:0]   pick;
	logic [SEL_W-1:0]    mask_left;
	logic [POS_W-1:0]    off_sub;
	logic [POS_W-1:0]    offset;
	logic [DATA_W-1:0]   item_data;
	logic                item_kind;

	assign advance    = !out_valid_q || m_axis_tready;
	assign load_ready = mask_q == '0 || (advance && $onehot(mask_q));

	always_comb begin
		pick = '0;
		for (int i = 0; i < SEL_W; i++) begin
			if (mask_q[i]) begin
				pick = PICK_W'(i);
			end
		end
		mask_left       = mask_q;
		mask_left[pick] = 1'b0;

		if (pick == PICK_W'(SEL_W - 1)) begin
			off_sub = POS_W'(CMP_AGE);
		end else begin
			off_sub = POS_W'(pick) + POS_W'(TAG_LAST - 1);
		end
		offset = held_q.pos - off_sub;

		item_data = '0;
		if (pick == '0) begin
			item_kind = KIND_SUMMARY;
			item_data[DATA_BITS-1:POS_W+2+3*WORD_W] = {held_q.complete, held_q.status,
				held_q.trunc_total, held_q.record_total, held_q.marker_total};
		end else if (pick == PICK_W'(SEL_W - 1)) begin
			item_kind = KIND_MARKER;
			// The window holds the version in its oldest bytes; the beat
			// carries the version lowest, then the size, then the frame word.
			item_data[POS_W+2+3*WORD_W-1:0] = {held_q.hdr[WORD_W-1:0],
				held_q.hdr[2*WORD_W-1:WORD_W], held_q.hdr[3*WORD_W-1:2*WORD_W],
				held_q.cmp_class, offset};
		end else begin
			item_kind = KIND_MARKER;
			item_data[POS_W+1:0] = {CLS_TRUNC, offset};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				mask_q <= burst.sel;
			end else if (advance) begin
				mask_q <= mask_left;
			end
			if (advance) begin
				out_valid_q <= mask_q != '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			held_q <= burst;
		end
		if (advance && mask_q != '0) begin
			out_data_q <= item_data;
			out_kind_q <= item_kind;
			out_last_q <= pick == '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

FILE: hdl/marker_header_scanner_top.sv
// ----------------------------------------------------------------------------
// marker_header_scanner_top: PRS3 marker header scanner
// Each result beat passes the burst holder and then the output register.
// Throughput: one byte per cycle while each byte causes at most one result and
// the output is not stalled; a byte that causes more than one result holds the
// input while the output register drains them, one beat per cycle unless stalled.
// Reset: arst_n clears the stream state, the open markers, the output and the
// source_verified register at once.
// ----------------------------------------------------------------------------
`default_nettype none

// The scan core keeps an eleven-byte history beside the incoming byte, a
// twelve-place line that follows each found tag until its twelfth header
// byte, and the stream counters. Every accepted beat produces a burst: the
// completed header, if any, and on the final byte the still open markers and
// the summary. The output sequencer holds one burst and emits it through a
// registered master port, so the input side is free again as soon as the
// last beat of the burst moves into the output register.
module marker_header_scanner_top
	import mhs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,

	// Configuration: source_verified, written whenever cfg_we is high.
	input  wire logic              cfg_we,
	input  wire logic              cfg_wdata,

	// Byte stream in.
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [7:0]        s_axis_tdata,   // [7:0] data_byte
	input  wire logic              s_axis_tlast,   // final_byte

	// Result stream out.
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	// tdata from bit 0 up: marker_offset[31:0], marker_class[1:0],
	// header_version[31:0], target_bytes[31:0], frame_word[31:0],
	// marker_total[6:0], record_total[6:0], truncated_total[6:0],
	// status[1:0], complete, then zero fill to 160 bits.
	output logic [DATA_W-1:0]      m_axis_tdata,
	output logic                   m_axis_tuser,   // record_kind
	output logic                   m_axis_tlast    // last_result
);

	burst_t burst;
	logic   fire;

	// A beat is taken only when the sequencer can hold its whole burst.
	assign fire = s_axis_tvalid && s_axis_tready;

	mhs_scan_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fire       (fire),
		.data_byte  (s_axis_tdata),
		.final_byte (s_axis_tlast),
		.burst      (burst)
	);

	mhs_out_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (fire),
		.burst         (burst),
		.load_ready    (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire
